// ===== hw/rtl/kmes_pkg.sv =====
// Shared types, constants and codes for the keypad matrix event scanner.
package kmes_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int MAX_SCAN_COLS = 4;
  localparam int ROWS_DEFAULT = 4;
  localparam int COLUMNS_DEFAULT = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int ACT_W = 3;
  localparam int KIND_W = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] LONG_HOLD_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RESET = 16'd500;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_HOLD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT = 2'd2;

  // per-column action decided by the front end
  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DOWN = 3'd1;
  localparam logic [ACT_W-1:0] ACT_UP_SHORT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UP_LONG = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REPEAT = 3'd4;

  // event kinds on the output stream
  localparam logic [KIND_W-1:0] EV_DOWN = 3'd0;
  localparam logic [KIND_W-1:0] EV_UP = 3'd1;
  localparam logic [KIND_W-1:0] EV_SHORT = 3'd2;
  localparam logic [KIND_W-1:0] EV_LONG = 3'd3;
  localparam logic [KIND_W-1:0] EV_REPEAT = 3'd4;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_hold_time;
    logic [CFG_W-1:0] repeat_interval;
  } cfg_t;

  function automatic int scan_cols(input int columns);
    return (columns < MAX_SCAN_COLS) ? columns : MAX_SCAN_COLS;
  endfunction

endpackage

// ===== hw/rtl/kmes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/kmes_front.sv =====
// Front end: accepts row scans, reads key state, classifies each column.
module kmes_front #(
  parameter int ROWS = kmes_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = kmes_pkg::COLUMNS_DEFAULT,
  localparam int SCAN_COLS = kmes_pkg::scan_cols(COLUMNS),
  localparam int ENTRY_W = 2 + kmes_pkg::ACT_W * SCAN_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kmes_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_row,
  input  logic [3:0]                  in_cols,
  input  logic [kmes_pkg::TIME_W-1:0] in_time,
  output logic                        q_push,
  output logic [ENTRY_W-1:0]          q_data,
  input  logic                        q_full
);

  localparam int TW = kmes_pkg::TIME_W;
  localparam int REC_W = SCAN_COLS * (1 + 3 * TW);
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic accept;
  logic advance;
  logic in_range;
  logic wr_en;
  logic [ROW_AW-1:0] in_addr;
  logic [ROW_AW-1:0] s1_addr;
  logic [REC_W-1:0] ram_rdata;
  logic [REC_W-1:0] rec;
  logic [REC_W-1:0] wr_data;
  logic [ROWS-1:0] row_valid;

  // stage 1 registers
  logic s1_valid;
  logic [1:0] s1_row;
  logic [3:0] s1_cols;
  logic [TW-1:0] s1_time;
  logic s1_rowvalid;
  logic s1_fwd;
  logic [REC_W-1:0] s1_fwd_data;

  logic [SCAN_COLS-1:0] cur_p, new_p;
  logic [SCAN_COLS-1:0][TW-1:0] cur_lct, cur_pst, cur_lrt;
  logic [SCAN_COLS-1:0][TW-1:0] new_lct, new_pst, new_lrt;
  logic [SCAN_COLS-1:0][kmes_pkg::ACT_W-1:0] acts;
  logic any_act;

  assign in_ready = !s1_valid || !q_full;
  assign accept = in_valid && in_ready;
  assign advance = s1_valid && !q_full;
  assign in_addr = ROW_AW'(in_row);
  assign s1_addr = ROW_AW'(s1_row);
  assign in_range = ({30'd0, s1_row} < 32'(ROWS));
  assign wr_en = advance && in_range;

  kmes_ram #(
    .WIDTH(REC_W),
    .DEPTH(ROWS)
  ) u_state_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(wr_data),
    .re   (accept),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        row_valid[s1_addr] <= 1'b1;
      end
    end
  end

  // payload of stage 1; a write landing on the same row as the new beat is forwarded
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= in_row;
      s1_cols <= in_cols;
      s1_time <= in_time;
      s1_rowvalid <= row_valid[in_addr];
      s1_fwd <= wr_en && (s1_addr == in_addr);
      s1_fwd_data <= wr_data;
    end
  end

  // rows never written read as the all-zero reset state
  assign rec = s1_fwd ? s1_fwd_data : (s1_rowvalid ? ram_rdata : '0);
  assign {cur_p, cur_lct, cur_pst, cur_lrt} = rec;

  always_comb begin
    new_p = cur_p;
    new_lct = cur_lct;
    new_pst = cur_pst;
    new_lrt = cur_lrt;
    acts = '0;
    for (int c = 0; c < SCAN_COLS; c++) begin
      if ((s1_cols[c] != cur_p[c]) &&
          ((s1_time - cur_lct[c]) >= {16'd0, cfg.debounce_time})) begin
        new_p[c] = s1_cols[c];
        new_lct[c] = s1_time;
        if (s1_cols[c]) begin
          new_pst[c] = s1_time;
          new_lrt[c] = s1_time;
          acts[c] = kmes_pkg::ACT_DOWN;
        end else if ((s1_time - cur_pst[c]) < {16'd0, cfg.long_hold_time}) begin
          acts[c] = kmes_pkg::ACT_UP_SHORT;
        end else begin
          acts[c] = kmes_pkg::ACT_UP_LONG;
        end
      end else if (cur_p[c] &&
                   ((s1_time - cur_lrt[c]) >= {16'd0, cfg.repeat_interval})) begin
        new_lrt[c] = s1_time;
        acts[c] = kmes_pkg::ACT_REPEAT;
      end
    end
  end

  assign wr_data = {new_p, new_lct, new_pst, new_lrt};
  assign any_act = |acts;
  assign q_push = wr_en && any_act;
  assign q_data = {acts, s1_row};

endmodule

// ===== hw/rtl/kmes_queue.sv =====
// Small register FIFO between the classifier and the event emitter.
module kmes_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = kmes_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/kmes_back.sv =====
// Back end: expands queued column actions into events, one per cycle while out_ready does not stall it.
module kmes_back #(
  parameter int COLUMNS = kmes_pkg::COLUMNS_DEFAULT,
  localparam int SCAN_COLS = kmes_pkg::scan_cols(COLUMNS),
  localparam int ENTRY_W = 2 + kmes_pkg::ACT_W * SCAN_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [ENTRY_W-1:0]          q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kmes_pkg::KIND_W-1:0] out_kind,
  output logic [1:0]                  out_row,
  output logic [1:0]                  out_col,
  output logic                        out_last
);

  logic cur_valid, cur_valid_next;
  logic cur_half, cur_half_next;
  logic [1:0] cur_row;
  logic [SCAN_COLS-1:0][kmes_pkg::ACT_W-1:0] cur_acts, cur_acts_next;

  logic found;
  logic later;
  logic [SCAN_COLS-1:0] sel_hot;
  logic [kmes_pkg::ACT_W-1:0] sel_act;
  logic [1:0] sel_col;
  logic is_up;
  logic emit;
  logic emit_last;
  logic [kmes_pkg::KIND_W-1:0] emit_kind;

  // lowest pending column goes first
  always_comb begin
    found = 1'b0;
    later = 1'b0;
    sel_hot = '0;
    sel_act = kmes_pkg::ACT_NONE;
    sel_col = '0;
    for (int c = 0; c < SCAN_COLS; c++) begin
      if (cur_acts[c] != kmes_pkg::ACT_NONE) begin
        if (!found) begin
          found = 1'b1;
          sel_hot[c] = 1'b1;
          sel_act = cur_acts[c];
          sel_col = 2'(c);
        end else begin
          later = 1'b1;
        end
      end
    end
  end

  assign is_up = (sel_act == kmes_pkg::ACT_UP_SHORT) || (sel_act == kmes_pkg::ACT_UP_LONG);
  assign emit = cur_valid && (!out_valid || out_ready);
  assign emit_last = !later && !(is_up && !cur_half);

  always_comb begin
    case (sel_act)
      kmes_pkg::ACT_DOWN:     emit_kind = kmes_pkg::EV_DOWN;
      kmes_pkg::ACT_UP_SHORT: emit_kind = cur_half ? kmes_pkg::EV_SHORT : kmes_pkg::EV_UP;
      kmes_pkg::ACT_UP_LONG:  emit_kind = cur_half ? kmes_pkg::EV_LONG : kmes_pkg::EV_UP;
      default:                emit_kind = kmes_pkg::EV_REPEAT;
    endcase
  end

  assign q_pop = !q_empty && (!cur_valid || (emit && emit_last));

  always_comb begin
    cur_valid_next = cur_valid;
    cur_half_next = cur_half;
    cur_acts_next = cur_acts;
    if (emit) begin
      if (is_up && !cur_half) begin
        cur_half_next = 1'b1;
      end else begin
        cur_half_next = 1'b0;
        for (int c = 0; c < SCAN_COLS; c++) begin
          if (sel_hot[c]) begin
            cur_acts_next[c] = kmes_pkg::ACT_NONE;
          end
        end
      end
      if (emit_last) begin
        cur_valid_next = 1'b0;
      end
    end
    if (q_pop) begin
      cur_valid_next = 1'b1;
      cur_half_next = 1'b0;
      cur_acts_next = q_data[ENTRY_W-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_half <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
      cur_half <= cur_half_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_acts <= cur_acts_next;
    if (q_pop) begin
      cur_row <= q_data[1:0];
    end
    if (emit) begin
      out_kind <= emit_kind;
      out_row <= cur_row;
      out_col <= sel_col;
      out_last <= emit_last;
    end
  end

endmodule

// ===== hw/rtl/keypad_matrix_event_scanner.sv =====
// Top level of the keypad matrix event scanner: config registers, front, queue, back.
//
// Usage: each s_* beat is one scanned row of the key matrix (row, pressed columns,
// millisecond timestamp). Per key the block debounces, tracks hold and repeat
// times with wrapping 32-bit differences, and sends events on m_*: DOWN on an
// accepted press, UP then a short or long press event on release, REPEAT while held.
// m_tlast marks the last event caused by one scan beat; a beat with no events
// produces nothing on m_*.
// Path: the scan beat passes the state RAM read, is classified and queued, and the
// emitter takes it from the queue and drives the output register.
// Throughput: one scan beat per cycle enters while the 4-entry action queue has
// room; the emitter sends one event per cycle while m_tready is high, and each
// scan beat causes 0 to 8 events.
// Back-to-back scans of the same row are forwarded around the state RAM.
// Reset (rst, synchronous): config returns to 20 / 1000 / 500 ms, all key state
// reads as released with zero times (per-row valid bits, no clearing pass).
// When m_tready is low, the output register holds, the queue fills and s_tready
// drops once the queue is full; nothing is lost.
// Config writes (cfg_wen) take effect next cycle and belong to idle periods.
module keypad_matrix_event_scanner #(
  parameter int ROWS = kmes_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = kmes_pkg::COLUMNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // scan input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] row_index, [5:2] column_pressed, [37:6] time_now
  // event output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] key_row, [3:2] key_column
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  output logic        m_tlast,   // last_of_run
  // config write port
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int SCAN_COLS = kmes_pkg::scan_cols(COLUMNS);
  localparam int ENTRY_W = 2 + kmes_pkg::ACT_W * SCAN_COLS;

  kmes_pkg::cfg_t cfg;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  logic [1:0] key_row;
  logic [1:0] key_col;

  // config registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= kmes_pkg::DEBOUNCE_RESET;
      cfg.long_hold_time <= kmes_pkg::LONG_HOLD_RESET;
      cfg.repeat_interval <= kmes_pkg::REPEAT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        kmes_pkg::REG_DEBOUNCE:  cfg.debounce_time <= cfg_wdata;
        kmes_pkg::REG_LONG_HOLD: cfg.long_hold_time <= cfg_wdata;
        kmes_pkg::REG_REPEAT:    cfg.repeat_interval <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kmes_front #(
    .ROWS(ROWS),
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_row  (s_tdata[1:0]),
    .in_cols (s_tdata[5:2]),
    .in_time (s_tdata[37:6]),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  kmes_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(kmes_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_rdata)
  );

  kmes_back #(
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_kind (m_tuser),
    .out_row  (key_row),
    .out_col  (key_col),
    .out_last (m_tlast)
  );

  assign m_tdata = {4'd0, key_col, key_row};

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("action queue overflow");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("action queue underflow");

  // an UP is always followed by its short or long press event in the same run
  a_up_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == kmes_pkg::EV_UP)) |-> !m_tlast)
    else $error("UP event marked last of run");

  // output is empty right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule
